[design/rha_pkg.sv]
`timescale 1ns / 1ps

package rha_pkg;

    // input and result field widths
    localparam int IDX_W   = 3;
    localparam int TOT_W   = 64;
    localparam int SEC_W   = 32;
    localparam int DELTA_W = 31;
    localparam int AVG_W   = 32;
    localparam int BKT_W   = 32;

    // minutes fit in 27 bits for any 32-bit seconds value
    localparam int MIN_W   = 27;
    localparam int REM60_W = 6;

    localparam int SECS_PER_MIN = 60;

    // seconds / 60 as a reciprocal product: exact for every 32-bit seconds value
    localparam logic [SEC_W-1:0] MIN_RECIP = 32'h8888_8889;
    localparam int               MIN_SHIFT = 37;

    // divider: dividend covers the widest window sum (64 slots of 32 bits)
    localparam int DIV_W  = 38;
    localparam int DVS_W  = 32;
    localparam int ITER_W = 6;

    localparam logic [DELTA_W-1:0] MAX_DELTA = '1;
    localparam logic [BKT_W-1:0]   MAX_BKT   = '1;
    localparam logic [AVG_W-1:0]   MAX_AVG   = '1;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;   // left-aligned: top iters bits hold the operand
        logic [DVS_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

endpackage

[design/rha_divider.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module rha_divider import rha_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    partial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign partial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = partial >= {1'b0, dvs_reg};
    assign diff    = partial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;

endmodule

[design/rha_bucket_store.sv]
`timescale 1ns / 1ps

// minute bucket memory with a zeroing sweep after reset
module rha_bucket_store import rha_pkg::*; #(
    parameter int ADDR_W = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BKT_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BKT_W-1:0]  wr_data,
    output logic              clear_busy
);

    logic [BKT_W-1:0]  bucket_mem [2**ADDR_W];
    logic [BKT_W-1:0]  rd_data_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BKT_W-1:0]  mem_wdata;

    always_comb begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bucket_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= bucket_mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clearing_reg;

endmodule

[design/rolling_hour_rate_averager_core.sv]
`timescale 1ns / 1ps

// rolling one-hour rate averager, one sliding window per counter
//
// input channel (s_valid / s_ready): one word per once-a-second sample of a
// counter: its index, its running total and the elapsed whole seconds.
// result channel (m_valid / m_ready): one word per input word, carrying the
// index, the per-second increase, the total and the window average.
//
// one word is worked at a time; s_ready drops from accept until the result
// is loaded into the output register. each word runs the increase, the two
// reciprocal products (seconds / 60, minute mod SLOTS) and the bucket update,
// then the window walk over W minute slots (1 to SLOTS), then drain, setup,
// the average on the serial divider and emit; at zero seconds the divide is
// skipped. a new word can be taken in the cycle after the result is loaded,
// so a word is never taken before the last one is done; an index that is out
// of range goes straight to emit, with zero increase and zero average.
//
// after reset a zeroing sweep runs over all 2^(CW+SW) entries of the bucket
// memory (512 with the defaults), with s_ready low. a stalled receiver holds the
// output register; the block finishes its current word and waits to load it.
module rolling_hour_rate_averager_core import rha_pkg::*; #(
    parameter int NUM_COUNTERS = 8,
    parameter int SLOTS        = 60
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [IDX_W-1:0]   s_counter_index,
    input  logic [TOT_W-1:0]   s_counter_total,
    input  logic [SEC_W-1:0]   s_elapsed_seconds,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [IDX_W-1:0]   m_result_index,
    output logic [DELTA_W-1:0] m_last_second_count,
    output logic [TOT_W-1:0]   m_running_total,
    output logic [AVG_W-1:0]   m_window_average
);

    localparam int CW     = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int SW     = $clog2(SLOTS);
    localparam int ADDR_W = CW + SW;
    localparam int SUM_W  = BKT_W + SW;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CLAMP_SECS = (SLOTS - 1) * SECS_PER_MIN;

    // minute mod SLOTS through a reciprocal product, exact for 27-bit minutes
    localparam int               SLOT_K     = 28 + SW;
    localparam logic [63:0]      SLOT_RECIP = (64'd1 << SLOT_K) / 64'(SLOTS) + 64'd1;

    // sequencer codes
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DELTA    = 4'd1;
    localparam logic [3:0] S_MIN      = 4'd2;
    localparam logic [3:0] S_MOD      = 4'd3;
    localparam logic [3:0] S_SLOT     = 4'd4;
    localparam logic [3:0] S_UPD      = 4'd5;
    localparam logic [3:0] S_WALK     = 4'd6;
    localparam logic [3:0] S_DRAIN    = 4'd7;
    localparam logic [3:0] S_AVG      = 4'd8;
    localparam logic [3:0] S_DIV_AVG  = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]         state_reg;
    logic               pend_reg;
    logic               m_valid_reg;

    // per-counter state in flops
    logic [TOT_W-1:0]   prev_tot_reg  [NUM_COUNTERS];
    logic [SW-1:0]      last_slot_reg [NUM_COUNTERS];

    // working word
    logic [CW-1:0]      ctr_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [SEC_W-1:0]   secs_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [MIN_W-1:0]   minutes_reg;
    logic [REM60_W-1:0] sec_rem_reg;
    logic               fresh_reg;
    logic [SEC_W-1:0]   window_reg;
    logic [SW-1:0]      pos_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [AVG_W-1:0]   avg_reg;
    logic [63:0]        mul_prod_reg;

    // output register
    logic [IDX_W-1:0]   m_idx_reg;
    logic [DELTA_W-1:0] m_delta_reg;
    logic [TOT_W-1:0]   m_total_reg;
    logic [AVG_W-1:0]   m_avg_reg;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               bkt_rd_en;
    logic [ADDR_W-1:0]  bkt_rd_addr;
    logic [BKT_W-1:0]   bkt_rd_data;
    logic               bkt_wr_en;
    logic [BKT_W-1:0]   bkt_wr_data;
    logic               clr_busy;

    logic               s_fire;
    logic               idx_ok;
    logic               out_free;
    logic [TOT_W-1:0]   prev_tot;
    logic [TOT_W-1:0]   tot_diff;
    logic [DELTA_W-1:0] delta_calc;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [MIN_W-1:0]   min_calc;
    logic [SEC_W-1:0]   sec_rem_full;
    logic [MIN_W-1:0]   slot_quo;
    logic [MIN_W-1:0]   slot_full;
    logic [SW-1:0]      slot_calc;
    logic [BKT_W:0]     bkt_sum;
    logic [BKT_W-1:0]   bkt_base;
    logic               win_clamp;
    logic [SW-1:0]      pos_prev;

    assign s_ready  = (state_reg == S_IDLE) && !clr_busy;
    assign s_fire   = s_valid && s_ready;
    assign idx_ok   = 32'(s_counter_index) < 32'(NUM_COUNTERS);
    assign out_free = !m_valid_reg || m_ready;

    // increase since the previous sample, zero if the counter went down
    assign prev_tot = prev_tot_reg[ctr_reg];
    assign tot_diff = total_reg - prev_tot;
    always_comb begin
        if (total_reg <= prev_tot) begin
            delta_calc = '0;
        end else if (|tot_diff[TOT_W-1:DELTA_W]) begin
            delta_calc = MAX_DELTA;
        end else begin
            delta_calc = tot_diff[DELTA_W-1:0];
        end
    end

    // one 32 by 32 multiplier: seconds times 1/60, then minutes times 1/SLOTS
    always_comb begin
        mul_a = secs_reg;
        mul_b = MIN_RECIP;
        if (state_reg == S_MOD) begin
            mul_a = 32'(minutes_reg);
            mul_b = SLOT_RECIP[31:0];
        end
    end

    // minutes and the seconds left over in the current minute
    assign min_calc     = mul_prod_reg[63:MIN_SHIFT];
    assign sec_rem_full = secs_reg - SEC_W'(min_calc) * SEC_W'(SECS_PER_MIN);

    // slot of the current minute in the ring
    assign slot_quo  = MIN_W'(mul_prod_reg >> SLOT_K);
    assign slot_full = minutes_reg - slot_quo * MIN_W'(SLOTS);
    assign slot_calc = slot_full[SW-1:0];

    // bucket update: a fresh minute starts from zero, saturate at full scale
    assign bkt_base    = fresh_reg ? '0 : bkt_rd_data;
    assign bkt_sum     = {1'b0, bkt_base} + (BKT_W+1)'(delta_reg);
    assign bkt_wr_data = bkt_sum[BKT_W] ? MAX_BKT : bkt_sum[BKT_W-1:0];
    assign bkt_wr_en   = (state_reg == S_UPD);

    // after a full hour: SLOTS-1 whole minutes plus the current partial one
    assign win_clamp = minutes_reg >= MIN_W'(SLOTS);

    // walk goes backward through the ring
    assign pos_prev = (pos_reg == '0) ? SW'(SLOTS - 1) : pos_reg - 1'b1;

    // bucket read: the current slot first, then the window walk
    always_comb begin
        bkt_rd_en   = 1'b0;
        bkt_rd_addr = {ctr_reg, pos_reg};
        if (state_reg == S_SLOT) begin
            bkt_rd_en   = 1'b1;
            bkt_rd_addr = {ctr_reg, slot_calc};
        end else if (state_reg == S_WALK) begin
            bkt_rd_en = 1'b1;
        end
    end

    // divider request: window sum / window seconds
    always_comb begin
        div_req = '0;
        if (state_reg == S_AVG && window_reg != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(sum_reg) << (DIV_W - SUM_W);
            div_req.divisor  = window_reg;
            div_req.iters    = ITER_W'(SUM_W);
        end
    end

    rha_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // write address is the current slot, held in pos_reg until the walk starts
    rha_bucket_store #(
        .ADDR_W (ADDR_W)
    ) u_bkt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (bkt_rd_en),
        .rd_addr    (bkt_rd_addr),
        .rd_data    (bkt_rd_data),
        .wr_en      (bkt_wr_en),
        .wr_addr    ({ctr_reg, pos_reg}),
        .wr_data    (bkt_wr_data),
        .clear_busy (clr_busy)
    );

    // sequencer and per-counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                prev_tot_reg[i]  <= '0;
                last_slot_reg[i] <= '0;
            end
        end else begin
            pend_reg <= (state_reg == S_WALK);
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= idx_ok ? S_DELTA : S_EMIT;
                    end
                end
                S_DELTA: begin
                    prev_tot_reg[ctr_reg] <= total_reg;
                    state_reg             <= S_MIN;
                end
                S_MIN: begin
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    state_reg <= S_SLOT;
                end
                S_SLOT: begin
                    last_slot_reg[ctr_reg] <= slot_calc;
                    state_reg              <= S_UPD;
                end
                S_UPD: begin
                    state_reg <= S_WALK;
                end
                S_WALK: begin
                    if (left_reg == CNT_W'(1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_AVG;
                end
                S_AVG: begin
                    state_reg <= (window_reg != '0) ? S_DIV_AVG : S_EMIT;
                end
                S_DIV_AVG: begin
                    if (div_rsp.done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working word datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ctr_reg   <= CW'(s_counter_index);
            idx_reg   <= s_counter_index;
            total_reg <= s_counter_total;
            secs_reg  <= s_elapsed_seconds;
            delta_reg <= '0;
            avg_reg   <= '0;
        end
        if (state_reg == S_DELTA) begin
            delta_reg <= delta_calc;
        end
        if (state_reg == S_DELTA || state_reg == S_MOD) begin
            mul_prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (state_reg == S_MIN) begin
            minutes_reg <= min_calc;
            sec_rem_reg <= sec_rem_full[REM60_W-1:0];
        end
        if (state_reg == S_SLOT) begin
            fresh_reg <= last_slot_reg[ctr_reg] != slot_calc;
            pos_reg   <= slot_calc;
        end
        if (state_reg == S_UPD) begin
            sum_reg    <= '0;
            left_reg   <= win_clamp ? CNT_W'(SLOTS) : CNT_W'(minutes_reg + 1'b1);
            window_reg <= win_clamp ? SEC_W'(CLAMP_SECS) + SEC_W'(sec_rem_reg) : secs_reg;
        end
        if (state_reg == S_WALK) begin
            pos_reg  <= pos_prev;
            left_reg <= left_reg - 1'b1;
        end
        // read data lands in the cycle after each walk read
        if (pend_reg) begin
            sum_reg <= sum_reg + SUM_W'(bkt_rd_data);
        end
        if (state_reg == S_DIV_AVG && div_rsp.done) begin
            avg_reg <= (|div_rsp.quotient[DIV_W-1:AVG_W]) ? MAX_AVG
                                                         : div_rsp.quotient[AVG_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            m_idx_reg   <= idx_reg;
            m_delta_reg <= delta_reg;
            m_total_reg <= total_reg;
            m_avg_reg   <= avg_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_result_index      = m_idx_reg;
    assign m_last_second_count = m_delta_reg;
    assign m_running_total     = m_total_reg;
    assign m_window_average    = m_avg_reg;

    // divider is never restarted while it is still working
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // no word is taken while the bucket sweep runs
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> state_reg == S_IDLE)
        else $error("sequencer left idle during bucket sweep");

    // walk length stays within the ring
    a_walk_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> (left_reg != '0) && (left_reg <= CNT_W'(SLOTS)))
        else $error("window walk length out of range");

    // an out-of-range index yields zero increase and zero average
    a_bad_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (32'(m_idx_reg) >= 32'(NUM_COUNTERS)))
            |-> (m_delta_reg == '0) && (m_avg_reg == '0))
        else $error("nonzero result for unknown counter");

endmodule

[tb/sv/rate_window_checker.sv]
`timescale 1ns / 1ps

module rate_window_checker import rha_pkg::*; #(
    parameter int NUM_COUNTERS = 8,
    parameter int SLOTS        = 60
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [IDX_W-1:0]   s_counter_index,
    input  logic [TOT_W-1:0]   s_counter_total,
    input  logic [SEC_W-1:0]   s_elapsed_seconds,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [IDX_W-1:0]   m_result_index,
    input  logic [DELTA_W-1:0] m_last_second_count,
    input  logic [TOT_W-1:0]   m_running_total,
    input  logic [AVG_W-1:0]   m_window_average,

    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [DELTA_W-1:0] increase;
        logic [TOT_W-1:0]   total;
        logic [AVG_W-1:0]   average;
    } rate_word_t;

    // per-counter window state
    logic [BKT_W-1:0] bucket_sum [NUM_COUNTERS][SLOTS];
    logic [TOT_W-1:0] prev_total [NUM_COUNTERS];
    logic [5:0]       last_slot  [NUM_COUNTERS];

    rate_word_t expected_rates [$];

    function automatic rate_word_t predict_rate(input logic [IDX_W-1:0] idx,
                                                input logic [TOT_W-1:0] total,
                                                input logic [SEC_W-1:0] secs);
        rate_word_t  w;
        logic [31:0] minutes;
        logic [31:0] span;
        logic [5:0]  slot;
        logic [5:0]  pos;
        logic [63:0] diff;
        logic [63:0] win_secs;
        logic [63:0] win_sum;
        logic [63:0] avg;
        logic [32:0] grown;
        int          k;
        w.idx      = idx;
        w.total    = total;
        w.increase = '0;
        w.average  = '0;
        if (idx < NUM_COUNTERS) begin
            minutes  = secs / SECS_PER_MIN;
            slot     = 6'(minutes % SLOTS);
            win_secs = {32'd0, secs};
            if (total > prev_total[idx]) begin
                diff       = total - prev_total[idx];
                w.increase = (diff > MAX_DELTA) ? MAX_DELTA : diff[DELTA_W-1:0];
            end
            prev_total[idx] = total;
            // a new minute starts its slot from zero
            if (last_slot[idx] != slot) begin
                last_slot[idx]         = slot;
                bucket_sum[idx][slot] = '0;
            end
            grown = {1'b0, bucket_sum[idx][slot]} + {2'b0, w.increase};
            bucket_sum[idx][slot] = grown[32] ? MAX_BKT : grown[31:0];
            span = minutes;
            // past the first full window: SLOTS-1 full minutes plus the partial one
            if (minutes >= SLOTS) begin
                span     = SLOTS - 1;
                win_secs = 64'(SLOTS * SECS_PER_MIN)
                           - (64'(SECS_PER_MIN) - 64'(secs % SECS_PER_MIN));
            end
            win_sum = '0;
            pos     = slot;
            for (k = 0; k <= span; k++) begin
                win_sum = win_sum + 64'(bucket_sum[idx][pos]);
                pos     = (pos == 0) ? 6'(SLOTS - 1) : pos - 6'd1;
            end
            if (win_secs != 0) begin
                avg       = win_sum / win_secs;
                w.average = (avg > MAX_AVG) ? MAX_AVG : avg[AVG_W-1:0];
            end
        end
        return w;
    endfunction

    task automatic note_mismatch(input string what, input rate_word_t want,
                                 input rate_word_t got);
        if (mismatches < 10)
            $display("%0t: %s: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                     $realtime, what, want.idx, want.increase, want.total, want.average,
                     got.idx, got.increase, got.total, got.average);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        rate_word_t got;
        rate_word_t want;
        if (!aresetn) begin
            for (int c = 0; c < NUM_COUNTERS; c++) begin
                prev_total[c] = '0;
                last_slot[c]  = '0;
                for (int s = 0; s < SLOTS; s++)
                    bucket_sum[c][s] = '0;
            end
            expected_rates.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_result_index, m_last_second_count, m_running_total,
                        m_window_average};
                if (expected_rates.size() == 0) begin
                    note_mismatch("result word with nothing expected", '0, got);
                end else begin
                    want = expected_rates.pop_front();
                    if (got.idx !== want.idx || got.increase !== want.increase ||
                        got.total !== want.total || got.average !== want.average)
                        note_mismatch("result word mismatch", want, got);
                end
            end
            if (s_valid && s_ready)
                expected_rates.push_back(predict_rate(s_counter_index, s_counter_total,
                                                      s_elapsed_seconds));
            outstanding = expected_rates.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rha_pkg::*;

    localparam int NUM_COUNTERS = 8;
    localparam int SLOTS        = 60;
    localparam int RANDOM_WORDS = 530;
    // long receiver hold-off, well past one full-window latency
    localparam int HOLD_CYCLES  = 1500;
    // drain time after the last result, well past one worst-case latency
    localparam int DRAIN_CYCLES = 400;
    localparam longint LIMIT_NS = 64'd8_000_000;

    logic               aclk;
    logic               aresetn;

    logic               s_valid;
    logic               s_ready;
    logic [IDX_W-1:0]   s_counter_index;
    logic [TOT_W-1:0]   s_counter_total;
    logic [SEC_W-1:0]   s_elapsed_seconds;

    logic               m_valid;
    logic               m_ready;
    logic [IDX_W-1:0]   m_result_index;
    logic [DELTA_W-1:0] m_last_second_count;
    logic [TOT_W-1:0]   m_running_total;
    logic [AVG_W-1:0]   m_window_average;

    int mismatches;
    int outstanding;

    // stimulus bookkeeping
    int sent_count   = 0;
    int burst_left   = 0;
    int hold_asked   = 0;
    int hold_served  = 0;

    // last sample sent per counter, so the random part continues each sequence
    logic [SEC_W-1:0] clock_sec [NUM_COUNTERS];
    logic [TOT_W-1:0] count_tot [NUM_COUNTERS];

    rolling_hour_rate_averager_core #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .SLOTS        (SLOTS)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_counter_index     (s_counter_index),
        .s_counter_total     (s_counter_total),
        .s_elapsed_seconds   (s_elapsed_seconds),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_index      (m_result_index),
        .m_last_second_count (m_last_second_count),
        .m_running_total     (m_running_total),
        .m_window_average    (m_window_average)
    );

    // watches both channels, predicts every result word and compares
    rate_window_checker #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .SLOTS        (SLOTS)
    ) u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_counter_index     (s_counter_index),
        .s_counter_total     (s_counter_total),
        .s_elapsed_seconds   (s_elapsed_seconds),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_index      (m_result_index),
        .m_last_second_count (m_last_second_count),
        .m_running_total     (m_running_total),
        .m_window_average    (m_window_average),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // offer one word at the falling edge and hold it until it is taken
    task automatic send_word(input logic [IDX_W-1:0] idx, input logic [TOT_W-1:0] tot,
                             input logic [SEC_W-1:0] secs);
        int gap;
        if (burst_left > 0) begin
            // keep offering while the receiver is held off
            gap = 0;
            burst_left--;
        end else if ((sent_count / 64) % 4 == 2) begin
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_counter_index   <= idx;
        s_counter_total   <= tot;
        s_elapsed_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        clock_sec[idx] = secs;
        count_tot[idx] = tot;
        sent_count++;
    endtask

    // drop valid and wait until every predicted result has been taken
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // next sample of a random counter: mostly a well-formed continuation of its
    // sequence, sometimes arbitrary values that restart the sequence
    task automatic random_sample();
        logic [IDX_W-1:0] c;
        logic [SEC_W-1:0] secs;
        logic [TOT_W-1:0] tot;
        int r;
        c    = $urandom_range(0, NUM_COUNTERS - 1);
        secs = clock_sec[c];
        tot  = count_tot[c];
        r    = $urandom_range(0, 99);
        if (r < 12) begin
            secs = (r < 4) ? SEC_W'($urandom_range(0, 59)) : SEC_W'($urandom);
            tot  = {$urandom, $urandom};
        end else begin
            // time steps from same second up to over an hour
            r = $urandom_range(0, 99);
            if (r < 3)
                secs = secs;
            else if (r < 45)
                secs = secs + $urandom_range(1, 3);
            else if (r < 70)
                secs = secs + $urandom_range(4, 70);
            else if (r < 90)
                secs = secs + $urandom_range(60, 400);
            else
                secs = secs + $urandom_range(900, 4000);
            r = $urandom_range(0, 99);
            if (r < 5)
                tot = tot - $urandom_range(1, 100000);      // counter went down
            else if (r < 12)
                tot = tot + 64'h8000_0000 + $urandom;       // increase saturates
            else
                tot = tot + $urandom_range(0, 5000);
        end
        send_word(c, tot, secs);
    endtask

    // receiver: random stalls, a steady phase, and the long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_served++;
            end else if ((sent_count / 64) % 4 == 1) begin
                m_ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int n;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_counter_index   = '0;
        s_counter_total   = '0;
        s_elapsed_seconds = '0;
        for (n = 0; n < NUM_COUNTERS; n++) begin
            clock_sec[n] = '0;
            count_tot[n] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed words
        send_word(0, 64'd0, 32'd0);                  // no time passed, nothing counted
        send_word(0, 64'd100, 32'd0);                // no time passed, increase still kept
        send_word(0, 64'd250, 32'd1);
        send_word(0, 64'd250, 32'd59);               // zero increase, end of first minute
        send_word(0, 64'd400, 32'd60);               // fresh slot cleared
        send_word(1, '1, 32'd59);                    // first sample: the increase from zero saturates
        send_word(1, 64'd5, 32'd60);                 // counter went down
        send_word(2, 64'h1_0000_0000, 32'd10);       // three saturated increases in one
        send_word(2, 64'h2_0000_0000, 32'd11);       // minute overflow the slot sum
        send_word(2, 64'h3_0000_0000, 32'd12);
        send_word(3, 64'd1000, 32'd3540);            // last minute of the first hour
        send_word(3, 64'd2000, 32'd3600);            // window clamp starts, slot 0 reused
        send_word(3, 64'd2500, 32'd3659);
        send_word(3, 64'd2600, 32'd3660);
        send_word(4, '1, '1);                        // widest field values
        send_word(4, 64'h5555_5555_5555_5555, 32'h5555_5555);
        send_word(5, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        send_word(5, 64'hAAAA_AAAA_AAAA_AAAB, 32'hAAAA_AAAA);  // same second again
        send_word(6, 64'd777, 32'd7199);
        send_word(6, 64'd800, 32'd10800);            // jump of just over an hour
        send_word(7, 64'd42, 32'd0);
        send_word(7, 64'd43, 32'd3600);              // exactly an hour on: same slot kept

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 150) begin
                // receiver stalls long while words keep coming: input backs up
                hold_asked++;
                burst_left = 12;
            end
            if (n == 330)
                drain_results();                     // sender waits for every result
            random_sample();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
